[rtl/core/sse_pkg.sv]
package sse_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 16;
    localparam int KEY_BITS   = 16;
    localparam int CMD_BITS   = 2;
    localparam int OCC_BITS   = 11;
    localparam int OR_GROUP   = 32;

    localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd2;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } sse_ctl_t;

endpackage

[rtl/core/sorted_set_engine.sv]
// Sorted set engine: holds up to CAPACITY distinct values in ascending order.
// The command channel takes one word per item (command, key_value); a word is
// accepted when cmd_valid is high and cmd_stall is low. Commands are query,
// insert and delete; command code 3 changes nothing.
// The response channel gives one word per item (success, store_full,
// occupancy), taken when rsp_valid is high and rsp_stall is low.
// An item passes through key capture, a compare in every cell, a
// registered OR tree over the match flags, then the shift of the cell row.
// The response is registered on the edge that finishes the update. The next
// command is accepted on the same edge that finishes the update, so the block
// takes no new item until the update of the last one finishes.
// If a response is still waiting, the update is held and cmd_stall stays high
// until rsp_stall drops; no response is lost or overwritten.
// Reset empties the set at once; no clearing pass is needed.
module sorted_set_engine #(
    parameter int CAPACITY   = sse_pkg::CAPACITY,
    parameter int VALUE_BITS = sse_pkg::VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [sse_pkg::CMD_BITS-1:0]  command,
    input  logic [sse_pkg::KEY_BITS-1:0]  key_value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          success,
    output logic                          store_full,
    output logic [sse_pkg::OCC_BITS-1:0]  occupancy
);

    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int KEY_WIDE   = (VALUE_BITS > sse_pkg::KEY_BITS) ? VALUE_BITS
                                                                 : sse_pkg::KEY_BITS;
    localparam int OCC_WIDE   = (CNT_BITS > sse_pkg::OCC_BITS) ? CNT_BITS
                                                               : sse_pkg::OCC_BITS;
    localparam int GROUP      = sse_pkg::OR_GROUP;
    localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [sse_pkg::CMD_BITS-1:0] cmd_reg;
    logic [sse_pkg::CMD_BITS-1:0] cmd_next;
    logic [VALUE_BITS-1:0]        key_reg;
    logic [VALUE_BITS-1:0]        key_next;
    logic [CNT_BITS-1:0]          count_reg;
    logic [CNT_BITS-1:0]          count_next;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    logic                         success_reg;
    logic                         success_next;
    logic                         full_reg;
    logic                         full_next;

    logic [KEY_WIDE-1:0]          key_wide;
    logic [OCC_WIDE-1:0]          occ_wide;
    logic                         accept;
    logic                         rsp_free;
    logic                         finish;
    logic                         present;
    logic                         is_full;
    logic                         do_ins;
    logic                         do_del;
    sse_pkg::sse_ctl_t            ctl;

    logic [VALUE_BITS-1:0]        cell_value [CAPACITY];
    logic [CAPACITY-1:0]          cell_lt;
    logic [NUM_GROUPS*GROUP-1:0]  cell_eq;
    logic [NUM_GROUPS-1:0]        group_hit;

    assign key_wide = KEY_WIDE'(key_value);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign finish   = (state_reg == ST_UPD) && rsp_free;
    assign accept   = cmd_valid && !cmd_stall;
    assign cmd_stall = !((state_reg == ST_IDLE) || finish);

    assign present = |group_hit;
    assign is_full = count_reg == CNT_BITS'(CAPACITY);
    assign do_ins  = finish && (cmd_reg == sse_pkg::CMD_INSERT) && !present && !is_full;
    assign do_del  = finish && (cmd_reg == sse_pkg::CMD_DELETE) && present;

    assign ctl.cmp = state_reg == ST_CMP;
    assign ctl.ins = do_ins;
    assign ctl.del = do_del;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        success_next   = success_reg;
        full_next      = full_reg;
        case (state_reg)
            ST_CMP:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    success_next   = ((cmd_reg == sse_pkg::CMD_QUERY) && present) ||
                                     do_ins || do_del;
                    full_next      = (cmd_reg == sse_pkg::CMD_INSERT) && !present &&
                                     is_full;
                    if (do_ins)
                    begin
                        count_next = count_reg + CNT_BITS'(1);
                    end
                    else if (do_del)
                    begin
                        count_next = count_reg - CNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (accept)
        begin
            state_next = ST_CMP;
            cmd_next   = command;
            key_next   = key_wide[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        success_reg <= success_next;
        full_reg    <= full_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_BITS-1:0] left_value;
            logic                  left_lt;
            logic [VALUE_BITS-1:0] right_value;

            if (gi == 0)
            begin : g_first
                assign left_value = '0;
                assign left_lt    = 1'b1;
            end
            else
            begin : g_inner_l
                assign left_value = cell_value[gi-1];
                assign left_lt    = cell_lt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_inner_r
                assign right_value = cell_value[gi+1];
            end

            sse_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_BITS   (CNT_BITS),
                .INDEX      (gi)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .key         (key_reg),
                .count       (count_reg),
                .left_value  (left_value),
                .left_lt     (left_lt),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .lt          (cell_lt[gi]),
                .eq          (cell_eq[gi])
            );
        end

        if (NUM_GROUPS * GROUP > CAPACITY)
        begin : g_pad
            assign cell_eq[NUM_GROUPS*GROUP-1:CAPACITY] = '0;
        end

        for (gi = 0; gi < NUM_GROUPS; gi++)
        begin : g_group
            sse_group #(
                .WIDTH (GROUP)
            ) u_group (
                .clk     (clk),
                .hits    (cell_eq[gi*GROUP +: GROUP]),
                .any_hit (group_hit[gi])
            );
        end
    endgenerate

    assign occ_wide   = OCC_WIDE'(count_reg);
    assign occupancy  = occ_wide[sse_pkg::OCC_BITS-1:0];
    assign rsp_valid  = rsp_valid_reg;
    assign success    = success_reg;
    assign store_full = full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("count exceeds capacity");

    a_rsp_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("response raised outside the update step");

    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(success_reg && full_reg))
        else $error("success and store_full both set");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(finish))
        else $error("count changed outside an update");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> $stable(success_reg) && $stable(full_reg))
        else $error("waiting response was overwritten");

endmodule

[rtl/core/sse_cell.sv]
module sse_cell #(
    parameter int VALUE_BITS = sse_pkg::VALUE_BITS,
    parameter int CNT_BITS   = 11,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  sse_pkg::sse_ctl_t     ctl,
    input  logic [VALUE_BITS-1:0] key,
    input  logic [CNT_BITS-1:0]   count,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic                  left_lt,
    input  logic [VALUE_BITS-1:0] right_value,
    output logic [VALUE_BITS-1:0] value,
    output logic                  lt,
    output logic                  eq
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  lt_reg;
    logic                  eq_reg;
    logic                  held;

    assign held = CNT_BITS'(INDEX) < count;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins && !lt_reg)
        begin
            value_next = left_lt ? key : left_value;
        end
        else if (ctl.del && !lt_reg)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (ctl.cmp)
        begin
            lt_reg <= held && (value_reg < key);
            eq_reg <= held && (value_reg == key);
        end
    end

    assign value = value_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

[rtl/core/sse_group.sv]
module sse_group #(
    parameter int WIDTH = sse_pkg::OR_GROUP
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] hits,
    output logic             any_hit
);

    logic any_reg;

    always_ff @(posedge clk)
    begin
        any_reg <= |hits;
    end

    assign any_hit = any_reg;

endmodule
